@@ hw/rtl/point_affine_transform_macros.svh @@
// Assertion macros shared by the point affine transform RTL.
`ifndef POINT_AFFINE_TRANSFORM_MACROS_SVH
`define POINT_AFFINE_TRANSFORM_MACROS_SVH

// Overlapping implication, sampled on clk and disabled during reset.
`define PAT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("point_affine_transform: assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("point_affine_transform: assertion failed");

`endif

@@ hw/rtl/pat_pkg.sv @@
// Shared types, constants and rounding helpers for the point affine transform.
package pat_pkg;

  // Configuration register file geometry.
  localparam int REG_BITS  = 16;
  localparam int NUM_REGS  = 8;
  localparam int ADDR_BITS = 4;

  // Fraction bits of the Q8.8 scale and shear factors.
  localparam int SCALE_FRAC_BITS = 8;

  // Intermediate coordinates are held clamped to +-(2^46 - 1), so 47 bits signed.
  localparam int WIDE_BITS = 47;
  // Working width for sums of products before rounding and clamping.
  localparam int CALC_BITS = 64;

  // Register stages from an accepted transaction to its result strobe.
  localparam int PIPE_DEPTH = 10;

  localparam logic signed [WIDE_BITS-1:0] WIDE_MAX = {1'b0, {(WIDE_BITS-1){1'b1}}};
  localparam logic signed [WIDE_BITS-1:0] WIDE_MIN =
    {1'b1, {(WIDE_BITS-2){1'b0}}, 1'b1};

  // Register indexes on the configuration port.
  typedef enum logic [ADDR_BITS-1:0] {
    REG_ROT_COS = 4'd0,
    REG_ROT_SIN = 4'd1,
    REG_SHIFT_X = 4'd2,
    REG_SHIFT_Y = 4'd3,
    REG_SCALE_X = 4'd4,
    REG_SCALE_Y = 4'd5,
    REG_SHEAR_X = 4'd6,
    REG_SHEAR_Y = 4'd7
  } pat_reg_t;

  // All configuration registers as seen by the datapath.
  typedef struct packed {
    logic signed [REG_BITS-1:0] rot_cos;
    logic signed [REG_BITS-1:0] rot_sin;
    logic signed [REG_BITS-1:0] shift_x;
    logic signed [REG_BITS-1:0] shift_y;
    logic signed [REG_BITS-1:0] scale_x;
    logic signed [REG_BITS-1:0] scale_y;
    logic signed [REG_BITS-1:0] shear_x;
    logic signed [REG_BITS-1:0] shear_y;
  } pat_cfg_t;

  localparam pat_cfg_t CFG_RESET = '{
    rot_cos: 16'sd16384,
    rot_sin: 16'sd0,
    shift_x: 16'sd0,
    shift_y: 16'sd0,
    scale_x: 16'sd256,
    scale_y: 16'sd256,
    shear_x: 16'sd0,
    shear_y: 16'sd0
  };

  // A point between pipeline sections, in the clamped intermediate range.
  typedef struct packed {
    logic signed [WIDE_BITS-1:0] x;
    logic signed [WIDE_BITS-1:0] y;
  } pat_pt_t;

  // Clamp a working value to the intermediate range.
  function automatic logic signed [WIDE_BITS-1:0] clamp_wide(
    input logic signed [CALC_BITS-1:0] v
  );
    logic signed [CALC_BITS-1:0] hi;
    logic signed [CALC_BITS-1:0] lo;
    hi = CALC_BITS'(WIDE_MAX);
    lo = CALC_BITS'(WIDE_MIN);
    if (v > hi) begin
      return WIDE_MAX;
    end else if (v < lo) begin
      return WIDE_MIN;
    end
    return v[WIDE_BITS-1:0];
  endfunction

  // Divide by 2^frac, rounding half away from zero. For negative values the
  // bias is one less than half, which turns the arithmetic shift's floor into
  // the symmetric rounding.
  function automatic logic signed [CALC_BITS-1:0] round_shift(
    input logic signed [CALC_BITS-1:0] v,
    input int unsigned                 frac
  );
    logic signed [CALC_BITS-1:0] half;
    logic signed [CALC_BITS-1:0] biased;
    half   = {{(CALC_BITS-1){1'b0}}, 1'b1} << (frac - 1);
    biased = v + half - {{(CALC_BITS-1){1'b0}}, v[CALC_BITS-1]};
    return biased >>> frac;
  endfunction

endpackage

@@ hw/rtl/pat_cfg_regs.sv @@
// Configuration register file for the point affine transform.
`include "point_affine_transform_macros.svh"

module pat_cfg_regs import pat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ADDR_BITS-1:0] cfg_addr,
  input  logic [REG_BITS-1:0]  cfg_data,
  output pat_cfg_t             cfg
);

  // Write decode; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROT_COS: cfg.rot_cos <= cfg_data;
        REG_ROT_SIN: cfg.rot_sin <= cfg_data;
        REG_SHIFT_X: cfg.shift_x <= cfg_data;
        REG_SHIFT_Y: cfg.shift_y <= cfg_data;
        REG_SCALE_X: cfg.scale_x <= cfg_data;
        REG_SCALE_Y: cfg.scale_y <= cfg_data;
        REG_SHEAR_X: cfg.shear_x <= cfg_data;
        REG_SHEAR_Y: cfg.shear_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A write to an unused index must not disturb any register.
  `PAT_ASSERT_NEXT(a_bad_index_ignored, cfg_we && (cfg_addr >= ADDR_BITS'(NUM_REGS)), $stable(cfg))

endmodule

@@ hw/rtl/pat_rotate.sv @@
// Rotation and translation section: products, rounding, then offset add.
module pat_rotate import pat_pkg::*; #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  pat_cfg_t                     cfg,
  output logic                         out_valid,
  output pat_pt_t                      pt_out
);

  localparam int PROD_BITS = COORD_BITS + REG_BITS;

  logic                        vld1;
  logic                        vld2;
  logic signed [PROD_BITS-1:0] px_c;
  logic signed [PROD_BITS-1:0] py_s;
  logic signed [PROD_BITS-1:0] px_s;
  logic signed [PROD_BITS-1:0] py_c;
  logic signed [WIDE_BITS-1:0] rot_x;
  logic signed [WIDE_BITS-1:0] rot_y;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  // Four rotation products.
  always_ff @(posedge clk) begin
    px_c <= x_in * cfg.rot_cos;
    py_s <= y_in * cfg.rot_sin;
    px_s <= x_in * cfg.rot_sin;
    py_c <= y_in * cfg.rot_cos;
  end

  // Combine, round off the Q2.14 fraction and clamp.
  always_ff @(posedge clk) begin
    rot_x <= clamp_wide(round_shift(CALC_BITS'(px_c) - CALC_BITS'(py_s), TRIG_FRAC_BITS));
    rot_y <= clamp_wide(round_shift(CALC_BITS'(px_s) + CALC_BITS'(py_c), TRIG_FRAC_BITS));
  end

  // Integer translation.
  always_ff @(posedge clk) begin
    pt_out.x <= clamp_wide(CALC_BITS'(rot_x) + CALC_BITS'(cfg.shift_x));
    pt_out.y <= clamp_wide(CALC_BITS'(rot_y) + CALC_BITS'(cfg.shift_y));
  end

endmodule

@@ hw/rtl/pat_scale.sv @@
// Per-axis scale section: Q8.8 product, then rounding and clamp.
module pat_scale import pat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  pat_pt_t  pt_in,
  input  pat_cfg_t cfg,
  output logic     out_valid,
  output pat_pt_t  pt_out
);

  localparam int PROD_BITS = WIDE_BITS + REG_BITS;

  logic                        vld1;
  logic signed [PROD_BITS-1:0] prod_x;
  logic signed [PROD_BITS-1:0] prod_y;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

  // Scale products.
  always_ff @(posedge clk) begin
    prod_x <= pt_in.x * cfg.scale_x;
    prod_y <= pt_in.y * cfg.scale_y;
  end

  // Drop the Q8.8 fraction and clamp.
  always_ff @(posedge clk) begin
    pt_out.x <= clamp_wide(round_shift(CALC_BITS'(prod_x), SCALE_FRAC_BITS));
    pt_out.y <= clamp_wide(round_shift(CALC_BITS'(prod_y), SCALE_FRAC_BITS));
  end

endmodule

@@ hw/rtl/pat_shear.sv @@
// Shear section: x is sheared by y first, then y by the new x.
module pat_shear import pat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  pat_pt_t  pt_in,
  input  pat_cfg_t cfg,
  output logic     out_valid,
  output pat_pt_t  pt_out
);

  localparam int PROD_BITS = WIDE_BITS + REG_BITS;

  logic [2:0]                  vld;
  logic signed [PROD_BITS-1:0] prod_a;
  logic signed [PROD_BITS-1:0] prod_b;
  logic signed [WIDE_BITS-1:0] x_a;
  logic signed [WIDE_BITS-1:0] y_a;
  logic signed [WIDE_BITS-1:0] x_b;
  logic signed [WIDE_BITS-1:0] y_b;
  logic signed [WIDE_BITS-1:0] x_c;
  logic signed [WIDE_BITS-1:0] y_c;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[1:0], in_valid};
      out_valid <= vld[2];
    end
  end

  // Product of y with the x shear factor.
  always_ff @(posedge clk) begin
    prod_a <= pt_in.y * cfg.shear_x;
    x_a    <= pt_in.x;
    y_a    <= pt_in.y;
  end

  // New x.
  always_ff @(posedge clk) begin
    x_b <= clamp_wide(CALC_BITS'(x_a) + round_shift(CALC_BITS'(prod_a), SCALE_FRAC_BITS));
    y_b <= y_a;
  end

  // Product of the new x with the y shear factor.
  always_ff @(posedge clk) begin
    prod_b <= x_b * cfg.shear_y;
    x_c    <= x_b;
    y_c    <= y_b;
  end

  // New y.
  always_ff @(posedge clk) begin
    pt_out.x <= x_c;
    pt_out.y <= clamp_wide(CALC_BITS'(y_c) + round_shift(CALC_BITS'(prod_b), SCALE_FRAC_BITS));
  end

endmodule

@@ hw/rtl/point_affine_transform.sv @@
// Accepted transactions pass rotate, scale, shear and the result register to done.
// Throughput: one point per cycle unless busy; a stall-free ten-stage pipeline sets it.
// The rotation, scale and shear multiplies each take a registered stage of their own.
// Reset is synchronous and active high; it empties the pipeline, loads the register
// defaults (identity transform) and holds busy high for the cycle after it is released.
`include "point_affine_transform_macros.svh"

module point_affine_transform import pat_pkg::*; #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] x_out,
  output logic signed [COORD_BITS-1:0] y_out,
  output logic                         clipped,
  input  logic                         cfg_we,
  input  logic [ADDR_BITS-1:0]         cfg_addr,
  input  logic [REG_BITS-1:0]          cfg_data
);

  localparam logic signed [WIDE_BITS-1:0] COORD_MAX =
    {{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [WIDE_BITS-1:0] COORD_MIN = ~COORD_MAX;
  localparam logic signed [COORD_BITS-1:0] OUT_MAX = COORD_MAX[COORD_BITS-1:0];
  localparam logic signed [COORD_BITS-1:0] OUT_MIN = COORD_MIN[COORD_BITS-1:0];

  pat_cfg_t cfg;
  logic     accept;
  logic     rot_valid;
  logic     scl_valid;
  logic     shr_valid;
  pat_pt_t  rot_pt;
  pat_pt_t  scl_pt;
  pat_pt_t  shr_pt;
  logic     x_hi;
  logic     x_lo;
  logic     y_hi;
  logic     y_lo;
  logic signed [COORD_BITS-1:0] x_sat;
  logic signed [COORD_BITS-1:0] y_sat;

  // Busy only covers reset and the cycle after it; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  pat_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pat_rotate #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .x_in      (x_in),
    .y_in      (y_in),
    .cfg       (cfg),
    .out_valid (rot_valid),
    .pt_out    (rot_pt)
  );

  pat_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .pt_in     (rot_pt),
    .cfg       (cfg),
    .out_valid (scl_valid),
    .pt_out    (scl_pt)
  );

  pat_shear u_shear (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .pt_in     (scl_pt),
    .cfg       (cfg),
    .out_valid (shr_valid),
    .pt_out    (shr_pt)
  );

  // Saturate to the output coordinate range.
  always_comb begin
    x_hi  = shr_pt.x > COORD_MAX;
    x_lo  = shr_pt.x < COORD_MIN;
    y_hi  = shr_pt.y > COORD_MAX;
    y_lo  = shr_pt.y < COORD_MIN;
    x_sat = shr_pt.x[COORD_BITS-1:0];
    y_sat = shr_pt.y[COORD_BITS-1:0];
    if (x_hi) begin
      x_sat = OUT_MAX;
    end else if (x_lo) begin
      x_sat = OUT_MIN;
    end
    if (y_hi) begin
      y_sat = OUT_MAX;
    end else if (y_lo) begin
      y_sat = OUT_MIN;
    end
  end

  // Result register; done marks the one cycle a transaction is shown.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= shr_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_out   <= x_sat;
    y_out   <= y_sat;
    clipped <= x_hi || x_lo || y_hi || y_lo;
  end

  // Every accepted transaction comes out after the full pipeline depth.
  `PAT_ASSERT_SAME(a_latency, accept, ##PIPE_DEPTH done)
  // No result appears without a transaction accepted the full pipeline depth before.
  `PAT_ASSERT_SAME(a_no_spurious, done, $past(accept, PIPE_DEPTH))
  // A clipped result has at least one coordinate at a range limit.
  `PAT_ASSERT_SAME(a_clip_at_limit, done && clipped, x_out == OUT_MAX || x_out == OUT_MIN || y_out == OUT_MAX || y_out == OUT_MIN)

endmodule

@@ verif/pat_checker.sv @@
// Scoreboard for the point affine transform: predicts each transaction and checks results.
module pat_checker import pat_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  input  logic               done,
  input  logic signed [15:0] x_out,
  input  logic signed [15:0] y_out,
  input  logic               clipped,
  input  logic               cfg_we,
  input  logic [ADDR_BITS-1:0] cfg_addr,
  input  logic [REG_BITS-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COORD_W   = 16;
  localparam int     TRIG_FRAC = 14;
  localparam longint WIDE_LIM  = (longint'(1) << (WIDE_BITS - 1)) - 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      clip;
  } point_res_t;

  // Shadow copy of the register file and the results still owed by the block.
  pat_cfg_t   cfg_shadow;
  point_res_t expected_points[$];

  function automatic longint widen(input logic signed [REG_BITS-1:0] v);
    return v;
  endfunction

  // Divide by 2^f and round ties away from zero, working on the magnitude.
  function automatic longint div_round(input longint v, input int f);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q   = (mag + (longint'(1) << (f - 1))) >>> f;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint limit_wide(input longint v);
    if (v > WIDE_LIM) return WIDE_LIM;
    if (v < -WIDE_LIM) return -WIDE_LIM;
    return v;
  endfunction

  // Rotate, translate, scale and shear one point, then saturate to the output width.
  function automatic point_res_t transform_point(input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py,
                                                 input pat_cfg_t k);
    longint     x;
    longint     y;
    longint     c;
    longint     s;
    longint     rx;
    longint     ry;
    longint     hi;
    longint     lo;
    point_res_t r;
    x  = px;
    y  = py;
    c  = widen(k.rot_cos);
    s  = widen(k.rot_sin);
    rx = limit_wide(div_round(x * c - y * s, TRIG_FRAC));
    ry = limit_wide(div_round(x * s + y * c, TRIG_FRAC));
    rx = limit_wide(rx + widen(k.shift_x));
    ry = limit_wide(ry + widen(k.shift_y));
    rx = limit_wide(div_round(rx * widen(k.scale_x), SCALE_FRAC_BITS));
    ry = limit_wide(div_round(ry * widen(k.scale_y), SCALE_FRAC_BITS));
    // The y shear sees the x value that has already been sheared.
    rx = limit_wide(rx + div_round(ry * widen(k.shear_x), SCALE_FRAC_BITS));
    ry = limit_wide(ry + div_round(rx * widen(k.shear_y), SCALE_FRAC_BITS));
    hi = (longint'(1) << (COORD_W - 1)) - 1;
    lo = -hi - 1;
    r.clip = 1'b0;
    if (rx > hi) begin
      rx = hi;
      r.clip = 1'b1;
    end
    if (rx < lo) begin
      rx = lo;
      r.clip = 1'b1;
    end
    if (ry > hi) begin
      ry = hi;
      r.clip = 1'b1;
    end
    if (ry < lo) begin
      ry = lo;
      r.clip = 1'b1;
    end
    r.x = rx[COORD_W-1:0];
    r.y = ry[COORD_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    point_res_t want;
    if (rst) begin
      cfg_shadow = CFG_RESET;
      expected_points.delete();
      fail_count = 0;
    end else begin
      // Each result strobe is matched against the oldest outstanding transaction.
      if (done) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: x_out %0d, y_out %0d, clipped %0d",
                 x_out, y_out, clipped);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          if (x_out !== want.x) begin
            $error("x_out: expected %0d, got %0d", want.x, x_out);
            fail_count++;
          end
          if (y_out !== want.y) begin
            $error("y_out: expected %0d, got %0d", want.y, y_out);
            fail_count++;
          end
          if (clipped !== want.clip) begin
            $error("clipped: expected %0d, got %0d", want.clip, clipped);
            fail_count++;
          end
        end
      end

      // An accepted transaction is predicted with the registers as they stand now.
      if (start && !busy) begin
        expected_points.push_back(transform_point(x_in, y_in, cfg_shadow));
      end

      // Writes to indexes past the last register are dropped.
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROT_COS: cfg_shadow.rot_cos = cfg_data;
          REG_ROT_SIN: cfg_shadow.rot_sin = cfg_data;
          REG_SHIFT_X: cfg_shadow.shift_x = cfg_data;
          REG_SHIFT_Y: cfg_shadow.shift_y = cfg_data;
          REG_SCALE_X: cfg_shadow.scale_x = cfg_data;
          REG_SCALE_Y: cfg_shadow.scale_y = cfg_data;
          REG_SHEAR_X: cfg_shadow.shear_x = cfg_data;
          REG_SHEAR_Y: cfg_shadow.shear_y = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_points.size();
  end

endmodule

@@ verif/testbench.sv @@
// Top of the point affine transform testbench: clock, reset, stimulus and verdict.
module testbench import pat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES     = 10;
  localparam int PHASE_PTS  = 75;
  localparam int DRAIN_MAX  = 1000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [15:0]   x_in;
  logic signed [15:0]   y_in;
  logic                 done;
  logic signed [15:0]   x_out;
  logic signed [15:0]   y_out;
  logic                 clipped;
  logic                 cfg_we;
  logic [ADDR_BITS-1:0] cfg_addr;
  logic [REG_BITS-1:0]  cfg_data;
  int                   fail_count;
  int                   pending;

  int idle_pct_table[3] = '{0, 57, 15};

  point_affine_transform u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .x_in     (x_in),
    .y_in     (y_in),
    .done     (done),
    .x_out    (x_out),
    .y_out    (y_out),
    .clipped  (clipped),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  pat_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .x_in       (x_in),
    .y_in       (y_in),
    .done       (done),
    .x_out      (x_out),
    .y_out      (y_out),
    .clipped    (clipped),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one point and hold it until the block takes the transaction.
  // Called at a rising edge; returns at the edge where the point was accepted.
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                            input int idle_pct);
    if (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    x_in  <= px;
    y_in  <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every outstanding transaction has returned.
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // One register write per edge; the caller lowers the write enable after a batch.
  task automatic write_cfg(input logic [ADDR_BITS-1:0] addr, input logic [REG_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [REG_BITS-1:0] data);
    for (int i = 0; i < NUM_REGS; i++) write_cfg(ADDR_BITS'(i), data);
    cfg_we <= 1'b0;
  endtask

  // Mostly modest coordinates so the chain stays out of saturation, plus full-range noise.
  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 16'(int'($urandom_range(2000)) - 1000);
      6, 7:             return 16'($urandom);
      8: begin
        case ($urandom_range(4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default:          return 16'(int'($urandom_range(16000)) - 8000);
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] edge_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      5:       return 16'h0100;
      6:       return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  // Pick a register setting: 0 gives a plausible transform, 1 raw bits, 2 corner values.
  task automatic random_cfg(input int mode);
    logic [REG_BITS-1:0] vals[NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) begin
      vals[i] = (mode == 1) ? 16'($urandom) : edge_value();
    end
    if (mode == 0) begin
      vals[REG_ROT_COS] = 16'(int'($urandom_range(32768)) - 16384);
      vals[REG_ROT_SIN] = 16'(int'($urandom_range(32768)) - 16384);
      vals[REG_SHIFT_X] = 16'(int'($urandom_range(1000)) - 500);
      vals[REG_SHIFT_Y] = 16'(int'($urandom_range(1000)) - 500);
      vals[REG_SCALE_X] = 16'(int'($urandom_range(1536)) - 768);
      vals[REG_SCALE_Y] = 16'(int'($urandom_range(1536)) - 768);
      vals[REG_SHEAR_X] = 16'(int'($urandom_range(256)) - 128);
      vals[REG_SHEAR_Y] = 16'(int'($urandom_range(256)) - 128);
    end
    for (int i = 0; i < NUM_REGS; i++) write_cfg(ADDR_BITS'(i), vals[i]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int drain;
    rst      = 1'b1;
    start    = 1'b0;
    x_in     = '0;
    y_in     = '0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Identity transform after reset: extremes and alternating bit patterns pass through.
    send_point(16'h0000, 16'h0000, 0);
    send_point(16'h7FFF, 16'h7FFF, 0);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7FFF, 16'h8000, 0);
    send_point(16'h8000, 16'h7FFF, 0);
    send_point(16'h5555, 16'hAAAA, 0);
    send_point(16'h0001, 16'hFFFF, 0);
    wait_idle();

    // Writes to indexes past the last register must leave the transform alone.
    write_cfg(ADDR_BITS'(NUM_REGS), 16'h1234);
    write_cfg({ADDR_BITS{1'b1}}, 16'hFFFF);
    cfg_we <= 1'b0;
    send_point(16'h0123, 16'hFEDC, 0);
    send_point(16'h8000, 16'h0001, 0);
    wait_idle();

    // Half scales put odd inputs exactly on a rounding tie, both signs.
    write_cfg(REG_SCALE_X, 16'h0080);
    write_cfg(REG_SCALE_Y, 16'hFF80);
    cfg_we <= 1'b0;
    send_point(16'h0001, 16'h0001, 0);
    send_point(16'hFFFF, 16'hFFFF, 0);
    send_point(16'h0003, 16'hFFFD, 0);
    send_point(16'hFFFD, 16'h0003, 0);
    wait_idle();

    // Every register at its most negative, then its most positive value;
    // the trig terms then lie beyond one and the outputs saturate.
    write_all(16'h8000);
    send_point(16'h7FFF, 16'h8000, 0);
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h0001, 16'h0000, 0);
    wait_idle();
    write_all(16'h7FFF);
    send_point(16'h7FFF, 16'h7FFF, 0);
    send_point(16'h8000, 16'h7FFF, 0);
    send_point(16'h0000, 16'hFFFF, 0);
    wait_idle();

    // Random phases, each with a fresh register setting; runs of three phases share an idling rate.
    for (int p = 0; p < PHASES; p++) begin
      random_cfg(p % 3);
      for (int n = 0; n < PHASE_PTS; n++) begin
        send_point(rand_coord(), rand_coord(), idle_pct_table[(p / 3) % 3]);
      end
      wait_idle();
    end

    // Drain any late strobes, then give the verdict.
    start <= 1'b0;
    drain = 0;
    @(negedge clk);
    while (pending != 0 && drain < DRAIN_MAX) begin
      @(negedge clk);
      drain++;
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (pending != 0) begin
      $error("%0d transactions never produced a result", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ point_affine_transform.f @@
+incdir+hw/rtl
hw/rtl/pat_pkg.sv
hw/rtl/pat_cfg_regs.sv
hw/rtl/pat_rotate.sv
hw/rtl/pat_scale.sv
hw/rtl/pat_shear.sv
hw/rtl/point_affine_transform.sv
verif/pat_checker.sv
verif/testbench.sv
